// ===== hdl/abt_pkg.sv =====
// Shared types and constants of the activity break timer.
package abt_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [15:0] LIMIT_SECONDS_RESET     = 16'd600;
   localparam logic [15:0] SNOOZE_SECONDS_RESET    = 16'd60;
   localparam logic [15:0] AUTORESET_SECONDS_RESET = 16'd120;

   typedef enum logic [2:0] {
      REG_LIMIT_SECONDS     = 3'd0,
      REG_LIMIT_ON          = 3'd1,
      REG_SNOOZE_SECONDS    = 3'd2,
      REG_AUTORESET_ON      = 3'd3,
      REG_AUTORESET_SECONDS = 3'd4,
      REG_COUNT_WHEN_ACTIVE = 3'd5
   } abt_reg_type;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_RESET   = 3'd1,
      CMD_SNOOZE  = 3'd2,
      CMD_ENABLE  = 3'd3,
      CMD_DISABLE = 3'd4
   } abt_cmd_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_STARTED = 3'd1,
      EV_STOPPED = 3'd2,
      EV_LIMIT   = 3'd3,
      EV_RESET   = 3'd4,
      EV_NATURAL = 3'd5
   } abt_event_type;

   typedef struct packed {
      logic [15:0] limit_seconds;
      logic        limit_on;
      logic [15:0] snooze_seconds;
      logic        autoreset_on;
      logic [15:0] autoreset_seconds;
      logic        count_when_active;
   } abt_cfg_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] now_seconds;
      logic        user_active;
   } abt_item_type;

   typedef struct packed {
      logic [2:0]  event_code;
      logic [31:0] elapsed_seconds;
      logic [31:0] idle_seconds;
   } abt_result_type;

endpackage

// ===== hdl/abt_csr.sv =====
// Configuration register file behind the APB-style port.
module abt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [abt_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [abt_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [abt_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output abt_pkg::abt_cfg_type                cfg_o
);
   import abt_pkg::*;

   abt_cfg_type cfg_ff, cfg_in;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign cfg_o   = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LIMIT_SECONDS:     cfg_in.limit_seconds     = csr_pwdata[15:0];
            REG_LIMIT_ON:          cfg_in.limit_on          = csr_pwdata[0];
            REG_SNOOZE_SECONDS:    cfg_in.snooze_seconds    = csr_pwdata[15:0];
            REG_AUTORESET_ON:      cfg_in.autoreset_on      = csr_pwdata[0];
            REG_AUTORESET_SECONDS: cfg_in.autoreset_seconds = csr_pwdata[15:0];
            REG_COUNT_WHEN_ACTIVE: cfg_in.count_when_active = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LIMIT_SECONDS:     csr_prdata = CSR_DATA_BITS'(cfg_ff.limit_seconds);
         REG_LIMIT_ON:          csr_prdata = CSR_DATA_BITS'(cfg_ff.limit_on);
         REG_SNOOZE_SECONDS:    csr_prdata = CSR_DATA_BITS'(cfg_ff.snooze_seconds);
         REG_AUTORESET_ON:      csr_prdata = CSR_DATA_BITS'(cfg_ff.autoreset_on);
         REG_AUTORESET_SECONDS: csr_prdata = CSR_DATA_BITS'(cfg_ff.autoreset_seconds);
         REG_COUNT_WHEN_ACTIVE: csr_prdata = CSR_DATA_BITS'(cfg_ff.count_when_active);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_seconds     <= LIMIT_SECONDS_RESET;
         cfg_ff.limit_on          <= 1'b1;
         cfg_ff.snooze_seconds    <= SNOOZE_SECONDS_RESET;
         cfg_ff.autoreset_on      <= 1'b1;
         cfg_ff.autoreset_seconds <= AUTORESET_SECONDS_RESET;
         cfg_ff.count_when_active <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/abt_core.sv =====
// Timer state and the single-pass update that one item applies to it.
module abt_core #(
   parameter int TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_i,
   input  abt_pkg::abt_item_type   item_i,
   input  abt_pkg::abt_cfg_type    cfg_i,
   output abt_pkg::abt_result_type result_o
);
   import abt_pkg::*;

   typedef enum logic [1:0] {
      RS_INVALID = 2'd0,
      RS_RUNNING = 2'd1,
      RS_STOPPED = 2'd2
   } run_state_type;

   typedef logic [TIME_BITS-1:0] time_type;

   logic          enabled_ff, enabled_in;
   run_state_type run_state_ff, run_state_in, prior_ff, prior_in;
   time_type      acc_ff, acc_in, limit_hit_ff, limit_hit_in;
   time_type      start_ff, start_in, stop_ff, stop_in;
   time_type      cleared_ff, cleared_in, due_reset_ff, due_reset_in;
   time_type      due_limit_ff, due_limit_in;

   logic [63:0]   now_wide, elapsed_wide, idle_wide;
   time_type      now_t, lim_t, snz_t, ars_t;
   time_type      el_old, idle_old, el_after;
   time_type      now_snz, now_lim, hit_snz, rst_at;
   time_type      start_dl, snooze_dl, clear_dl, stop_dr, stop_dl;
   logic          running, limit_armed, want_change, tick_start, tick_stop;
   logic          stop_en, fire_lim, fire_rst, natural;
   abt_event_type ev;

   // Tick transition results
   run_state_type rs1;
   time_type      acc1, st1, sp1, dr1, dl1;

   assign now_wide = 64'(item_i.now_seconds);
   assign now_t    = now_wide[TIME_BITS-1:0];
   assign lim_t    = TIME_BITS'(cfg_i.limit_seconds);
   assign snz_t    = TIME_BITS'(cfg_i.snooze_seconds);
   assign ars_t    = TIME_BITS'(cfg_i.autoreset_seconds);

   assign running     = (run_state_ff == RS_RUNNING);
   assign limit_armed = enabled_ff && cfg_i.limit_on && (cfg_i.limit_seconds != '0);

   assign el_old   = (start_ff != '0) ? acc_ff + (now_t - start_ff) : acc_ff;
   assign idle_old = (stop_ff != '0) ? now_t - stop_ff : '0;

   assign now_snz = now_t + snz_t;
   assign now_lim = now_t + lim_t;
   assign hit_snz = limit_hit_ff + snz_t;
   assign rst_at  = now_t + ars_t;

   // Limit plans for start, snooze and clear
   assign start_dl  = (limit_hit_ff != '0) ? hit_snz :
                      (limit_armed ? now_lim - acc_ff : '0);
   assign snooze_dl = (now_t != '0) ? now_snz :
                      ((limit_armed && running) ? start_ff + lim_t - acc_ff : '0);
   assign clear_dl  = limit_armed ? now_lim : '0;

   // Stop path shared by tick, enable and disable
   assign stop_en = (item_i.command == CMD_ENABLE)  ? 1'b1 :
                    (item_i.command == CMD_DISABLE) ? 1'b0 : enabled_ff;
   assign stop_dr = (stop_en && (now_t != '0) && cfg_i.autoreset_on &&
                     (cfg_i.autoreset_seconds != '0) && (rst_at > cleared_ff)) ? rst_at : '0;
   assign stop_dl = (limit_hit_ff != '0) ? hit_snz : '0;

   assign want_change = enabled_ff && (item_i.user_active != running);
   assign tick_start  = want_change && (item_i.user_active == cfg_i.count_when_active);
   assign tick_stop   = want_change && (item_i.user_active != cfg_i.count_when_active);

   always_comb begin
      rs1  = run_state_ff;
      acc1 = acc_ff;
      st1  = start_ff;
      sp1  = stop_ff;
      dr1  = due_reset_ff;
      dl1  = due_limit_ff;
      if (tick_start) begin
         rs1 = RS_RUNNING;
         st1 = now_t;
         sp1 = '0;
         dr1 = '0;
         dl1 = start_dl;
      end else if (tick_stop) begin
         rs1  = RS_STOPPED;
         acc1 = el_old;
         st1  = '0;
         sp1  = now_t;
         dr1  = stop_dr;
         dl1  = stop_dl;
      end
   end

   assign fire_lim = (dl1 != '0) && (now_t >= dl1);
   assign fire_rst = (dr1 != '0) && (now_t >= dr1);
   // A start keeps the count where it was; a stop folds in the same time el_old does
   assign el_after = tick_start ? acc_ff : el_old;
   assign natural  = (lim_t >= el_after);

   always_comb begin
      enabled_in   = enabled_ff;
      run_state_in = run_state_ff;
      prior_in     = prior_ff;
      acc_in       = acc_ff;
      limit_hit_in = limit_hit_ff;
      start_in     = start_ff;
      stop_in      = stop_ff;
      cleared_in   = cleared_ff;
      due_reset_in = due_reset_ff;
      due_limit_in = due_limit_ff;
      ev           = EV_NONE;
      unique case (item_i.command)
         CMD_TICK: begin
            run_state_in = rs1;
            prior_in     = rs1;
            acc_in       = acc1;
            start_in     = st1;
            stop_in      = sp1;
            due_reset_in = dr1;
            due_limit_in = dl1;
            if (fire_lim) begin
               due_limit_in = now_snz;
               limit_hit_in = now_t;
               ev           = EV_LIMIT;
            end else if (fire_rst) begin
               acc_in       = '0;
               limit_hit_in = '0;
               cleared_in   = now_t;
               due_reset_in = '0;
               if (rs1 == RS_RUNNING) begin
                  start_in     = now_t;
                  stop_in      = '0;
                  due_limit_in = clear_dl;
               end else begin
                  start_in     = '0;
                  due_limit_in = '0;
               end
               ev = natural ? EV_NATURAL : EV_RESET;
            end else if (rs1 == RS_RUNNING && prior_ff == RS_STOPPED) begin
               ev = EV_STARTED;
            end else if (rs1 == RS_STOPPED && prior_ff == RS_RUNNING) begin
               ev = EV_STOPPED;
            end
         end
         CMD_RESET: begin
            acc_in       = '0;
            limit_hit_in = '0;
            cleared_in   = now_t;
            due_reset_in = '0;
            if (running) begin
               start_in     = now_t;
               stop_in      = '0;
               due_limit_in = clear_dl;
            end else begin
               start_in     = '0;
               due_limit_in = '0;
            end
         end
         CMD_SNOOZE: begin
            if (el_old >= lim_t) begin
               limit_hit_in = now_t;
               due_limit_in = snooze_dl;
            end
         end
         CMD_ENABLE: begin
            enabled_in   = 1'b1;
            run_state_in = RS_STOPPED;
            acc_in       = el_old;
            start_in     = '0;
            stop_in      = now_t;
            due_reset_in = stop_dr;
            due_limit_in = stop_dl;
         end
         CMD_DISABLE: begin
            enabled_in   = 1'b0;
            run_state_in = RS_STOPPED;
            acc_in       = el_old;
            start_in     = '0;
            stop_in      = now_t;
            due_reset_in = stop_dr;
            due_limit_in = stop_dl;
         end
         default: ;
      endcase
   end

   assign elapsed_wide          = 64'(el_old);
   assign idle_wide             = 64'(idle_old);
   assign result_o.event_code      = ev;
   assign result_o.elapsed_seconds = elapsed_wide[31:0];
   assign result_o.idle_seconds    = idle_wide[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         run_state_ff <= RS_INVALID;
         prior_ff     <= RS_INVALID;
         acc_ff       <= '0;
         limit_hit_ff <= '0;
         start_ff     <= '0;
         stop_ff      <= '0;
         cleared_ff   <= '0;
         due_reset_ff <= '0;
         due_limit_ff <= '0;
      end else if (step_i) begin
         enabled_ff   <= enabled_in;
         run_state_ff <= run_state_in;
         prior_ff     <= prior_in;
         acc_ff       <= acc_in;
         limit_hit_ff <= limit_hit_in;
         start_ff     <= start_in;
         stop_ff      <= stop_in;
         cleared_ff   <= cleared_in;
         due_reset_ff <= due_reset_in;
         due_limit_ff <= due_limit_in;
      end
   end

   a_enable_sets_flag: assert property (@(posedge clock) disable iff (reset)
      step_i && item_i.command == CMD_ENABLE |=> enabled_ff)
      else $error("enable item did not set the enabled flag");

   a_due_reset_only_stopped: assert property (@(posedge clock) disable iff (reset)
      due_reset_ff != '0 |-> run_state_ff == RS_STOPPED)
      else $error("auto-reset armed while not stopped");

   a_start_time_only_running: assert property (@(posedge clock) disable iff (reset)
      start_ff != '0 |-> run_state_ff == RS_RUNNING)
      else $error("start time held while not running");

   a_stop_time_only_stopped: assert property (@(posedge clock) disable iff (reset)
      stop_ff != '0 |-> run_state_ff == RS_STOPPED)
      else $error("stop time held while not stopped");

endmodule

// ===== hdl/activity_break_timer.sv =====
// Accepted items pass through the input register, then the result register.
// Throughput: one item per cycle; the input stalls only while both the input and
//   result registers are full and rsp_ready is low.
// Every item yields exactly one result item.
// Reset: synchronous, active high; clears the timer state, drops both stages
//   and loads the configuration registers with their defaults.
module activity_break_timer #(
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input item channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_command,
   input  logic [31:0]                       req_now_seconds,
   input  logic                              req_user_active,
   // result item channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_event_code,
   output logic [31:0]                       rsp_elapsed_seconds,
   output logic [31:0]                       rsp_idle_seconds,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [abt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [abt_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [abt_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import abt_pkg::*;

   abt_cfg_type    cfg;
   abt_item_type   in_item_ff, in_item_in;
   abt_result_type rsp_result_ff, core_result;
   logic           in_valid_ff, in_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           advance;

   // Register file; writes complete in the access phase with no wait states
   abt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg_o       (cfg)
   );
   assign csr_pready = 1'b1;

   // Advance the held item into the timer whenever the result register is
   // empty or being emptied this cycle; the timer state updates at that edge.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_item_in.command     = req_command;
   assign in_item_in.now_seconds = req_now_seconds;
   assign in_item_in.user_active = req_user_active;

   // Input stage holds its item until the timer consumes it
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   // Result stage: filled on advance, dropped once taken
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   abt_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_i   (advance),
      .item_i   (in_item_ff),
      .cfg_i    (cfg),
      .result_o (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_code      = rsp_result_ff.event_code;
   assign rsp_elapsed_seconds = rsp_result_ff.elapsed_seconds;
   assign rsp_idle_seconds    = rsp_result_ff.idle_seconds;

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("timer advanced but no result item was registered");

   a_empty_result_means_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled while the result register was empty");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held input item lost or changed while stalled");

endmodule

// ===== verif/abt_checker.sv =====
// Checker for the activity break timer: predicts each result item and compares it.
module abt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_now_seconds,
   input  logic        req_user_active,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_event_code,
   input  logic [31:0] rsp_elapsed_seconds,
   input  logic [31:0] rsp_idle_seconds,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [abt_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [abt_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import abt_pkg::*;

   typedef enum logic [1:0] {
      RUN_INVALID = 2'd0,
      RUN_ACTIVE  = 2'd1,
      RUN_STOPPED = 2'd2
   } run_mode_type;

   abt_cfg_type    cfg;
   logic           enabled;
   run_mode_type   mode, last_mode;
   logic [31:0]    banked, limit_mark, run_since, idle_since;
   logic [31:0]    cleared_at, autoreset_due, limit_due;
   abt_result_type timer_results[$];

   function automatic void clear_timer();
      cfg.limit_seconds     = LIMIT_SECONDS_RESET;
      cfg.limit_on          = 1'b1;
      cfg.snooze_seconds    = SNOOZE_SECONDS_RESET;
      cfg.autoreset_on      = 1'b1;
      cfg.autoreset_seconds = AUTORESET_SECONDS_RESET;
      cfg.count_when_active = 1'b1;
      enabled       = 1'b0;
      mode          = RUN_INVALID;
      last_mode     = RUN_INVALID;
      banked        = '0;
      limit_mark    = '0;
      run_since     = '0;
      idle_since    = '0;
      cleared_at    = '0;
      autoreset_due = '0;
      limit_due     = '0;
   endfunction

   function automatic logic [31:0] elapsed_at(input logic [31:0] now);
      return (run_since != 0) ? banked + (now - run_since) : banked;
   endfunction

   function automatic logic [31:0] idle_at(input logic [31:0] now);
      return (idle_since != 0) ? now - idle_since : 32'd0;
   endfunction

   function automatic void arm_limit();
      if (limit_mark != 0)
         limit_due = limit_mark + 32'(cfg.snooze_seconds);
      else if (enabled && mode == RUN_ACTIVE && cfg.limit_on && cfg.limit_seconds != 0)
         limit_due = run_since + 32'(cfg.limit_seconds) - banked;
      else
         limit_due = '0;
   endfunction

   function automatic void arm_autoreset();
      logic [31:0] due;
      due = idle_since + 32'(cfg.autoreset_seconds);
      autoreset_due = '0;
      if (enabled && mode == RUN_STOPPED && idle_since != 0 && cfg.autoreset_on &&
          cfg.autoreset_seconds != 0 && due > cleared_at)
         autoreset_due = due;
   endfunction

   function automatic void begin_run(input logic [31:0] now);
      run_since     = now;
      idle_since    = '0;
      autoreset_due = '0;
      mode          = RUN_ACTIVE;
      arm_limit();
   endfunction

   function automatic void end_run(input logic [31:0] now);
      idle_since = now;
      if (run_since != 0)
         banked = banked + (idle_since - run_since);
      run_since = '0;
      mode      = RUN_STOPPED;
      arm_autoreset();
      arm_limit();
   endfunction

   function automatic void clear_count(input logic [31:0] now);
      banked        = '0;
      limit_mark    = '0;
      cleared_at    = now;
      autoreset_due = '0;
      if (mode == RUN_ACTIVE) begin
         run_since  = now;
         idle_since = '0;
         arm_limit();
      end else begin
         run_since = '0;
         limit_due = '0;
      end
   endfunction

   // Apply one item to the timer copy and return the result it reports.
   function automatic abt_result_type advance_timer(input logic [2:0] cmd,
                                                    input logic [31:0] now,
                                                    input logic active);
      abt_result_type res;
      logic           under_limit;
      res.event_code      = EV_NONE;
      res.elapsed_seconds = elapsed_at(now);
      res.idle_seconds    = idle_at(now);
      case (cmd)
         CMD_TICK: begin
            if (active && mode != RUN_ACTIVE) begin
               if (enabled) begin
                  if (cfg.count_when_active) begin_run(now);
                  else end_run(now);
               end
            end else if (!active && mode == RUN_ACTIVE) begin
               if (enabled) begin
                  if (cfg.count_when_active) end_run(now);
                  else begin_run(now);
               end
            end
            if (limit_due != 0 && now >= limit_due) begin
               limit_due  = '0;
               limit_mark = now;
               arm_limit();
               res.event_code = EV_LIMIT;
            end else if (autoreset_due != 0 && now >= autoreset_due) begin
               autoreset_due = '0;
               under_limit = 32'(cfg.limit_seconds) >= elapsed_at(now);
               clear_count(now);
               res.event_code = under_limit ? EV_NATURAL : EV_RESET;
            end else if (mode == RUN_ACTIVE && last_mode == RUN_STOPPED) begin
               res.event_code = EV_STARTED;
            end else if (mode == RUN_STOPPED && last_mode == RUN_ACTIVE) begin
               res.event_code = EV_STOPPED;
            end
            last_mode = mode;
         end
         CMD_RESET: clear_count(now);
         CMD_SNOOZE: begin
            if (elapsed_at(now) >= 32'(cfg.limit_seconds)) begin
               limit_mark = now;
               arm_limit();
            end
         end
         CMD_ENABLE: begin
            enabled = 1'b1;
            end_run(now);
         end
         CMD_DISABLE: begin
            enabled = 1'b0;
            end_run(now);
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void store_reg(input abt_reg_type idx, input logic [31:0] value);
      case (idx)
         REG_LIMIT_SECONDS:     cfg.limit_seconds     = value[15:0];
         REG_LIMIT_ON:          cfg.limit_on          = value[0];
         REG_SNOOZE_SECONDS:    cfg.snooze_seconds    = value[15:0];
         REG_AUTORESET_ON:      cfg.autoreset_on      = value[0];
         REG_AUTORESET_SECONDS: cfg.autoreset_seconds = value[15:0];
         REG_COUNT_WHEN_ACTIVE: cfg.count_when_active = value[0];
         default: ;
      endcase
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      clear_timer();
   end

   always @(posedge clock) begin
      abt_result_type want;
      if (reset) begin
         clear_timer();
         timer_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (timer_results.size() == 0) begin
               $error("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = timer_results.pop_front();
               if (rsp_event_code !== want.event_code) begin
                  $error("event_code: expected %0d, got %0d", want.event_code, rsp_event_code);
                  fail_count++;
               end
               if (rsp_elapsed_seconds !== want.elapsed_seconds) begin
                  $error("elapsed_seconds: expected %0d, got %0d",
                         want.elapsed_seconds, rsp_elapsed_seconds);
                  fail_count++;
               end
               if (rsp_idle_seconds !== want.idle_seconds) begin
                  $error("idle_seconds: expected %0d, got %0d",
                         want.idle_seconds, rsp_idle_seconds);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            timer_results.push_back(advance_timer(req_command, req_now_seconds,
                                                  req_user_active));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            store_reg(abt_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]), csr_pwdata);
      end
      pending = timer_results.size();
   end

endmodule

// ===== verif/testbench.sv =====
// Top of the activity break timer testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import abt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   logic [2:0]  req_command;
   logic [31:0] req_now_seconds;
   logic        req_user_active;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_event_code;
   logic [31:0] rsp_elapsed_seconds, rsp_idle_seconds;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata, csr_prdata;

   int          fail_count, pending;
   int          cycle_count;
   // idling enables random gaps on both sides; long_hold asks for one long receiver stall
   logic        idling, long_hold;
   // running wall clock of the well-formed sessions
   logic [31:0] wall_s;

   activity_break_timer u_dut (.*);

   abt_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Watchdog: give up if the run stalls far past its slowest correct length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver side: random stall bursts, plus one long hold-off on request so the
   // block fills up and pushes back on its input.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (64) @(negedge clock);
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one item and hold it until the block takes it; sometimes insert a gap first.
   task automatic send_item(input logic [2:0] cmd, input logic [31:0] now,
                            input logic act);
      @(negedge clock);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_now_seconds <= now;
      req_user_active <= act;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every expected result item has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (3) @(negedge clock);
   endtask

   // Two-phase register write: setup cycle, then access cycle.
   task automatic write_reg(input abt_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_config(input logic [15:0] limit, input logic limit_en,
                              input logic [15:0] snooze, input logic ar_en,
                              input logic [15:0] ar_span, input logic count_active);
      write_reg(REG_LIMIT_SECONDS, 32'(limit));
      write_reg(REG_LIMIT_ON, 32'(limit_en));
      write_reg(REG_SNOOZE_SECONDS, 32'(snooze));
      write_reg(REG_AUTORESET_ON, 32'(ar_en));
      write_reg(REG_AUTORESET_SECONDS, 32'(ar_span));
      write_reg(REG_COUNT_WHEN_ACTIVE, 32'(count_active));
   endtask

   // One session: enable, then mostly ticks at a slowly advancing time with runs of
   // activity and idle, occasional long jumps to reach the auto-reset, a few other
   // commands, and some noise items at arbitrary times.
   task automatic play_session(input int n_items, input int unsigned span);
      logic        active;
      logic [2:0]  cmd;
      int unsigned pick;
      active = 1'b0;
      send_item(CMD_ENABLE, wall_s, 1'b0);
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 15) == 0)
            wall_s += $urandom_range(0, 2 * span);
         else
            wall_s += $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0)
            active = ~active;
         if (pick < 80)      cmd = CMD_TICK;
         else if (pick < 85) cmd = CMD_SNOOZE;
         else if (pick < 89) cmd = CMD_RESET;
         else if (pick < 93) cmd = CMD_ENABLE;
         else if (pick < 96) cmd = CMD_DISABLE;
         else                cmd = 3'(CMD_DISABLE) + 3'($urandom_range(1, 3));
         if (pick >= 98)
            send_item(CMD_TICK, $urandom(), 1'($urandom_range(0, 1)));
         else
            send_item(cmd, wall_s, active);
      end
   endtask

   initial begin
      logic [15:0] limit, snooze, ar_span;
      logic        limit_en, ar_en, count_active;
      int unsigned span;
      cycle_count     = 0;
      reset           = 1'b1;
      idling          = 1'b1;
      long_hold       = 1'b0;
      wall_s          = 32'd2000;
      req_valid       = 1'b0;
      req_command     = CMD_TICK;
      req_now_seconds = '0;
      req_user_active = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk with the reset configuration.
      send_item(CMD_TICK, 32'd0, 1'b1);            // tick while disabled, time zero
      send_item(CMD_ENABLE, 32'd0, 1'b0);          // stop stamped at zero reads unset
      send_item(CMD_TICK, 32'd5, 1'b1);            // start
      send_item(3'(CMD_DISABLE) + 3'd1, 32'd6, 1'b1);   // unknown commands change nothing
      send_item(3'(CMD_DISABLE) + 3'd2, 32'd7, 1'b0);
      send_item(3'(CMD_DISABLE) + 3'd3, 32'hFFFF_FFFF, 1'b1);
      send_item(CMD_SNOOZE, 32'd8, 1'b1);          // snooze below the limit
      send_item(CMD_TICK, 32'd700, 1'b1);          // limit reached
      send_item(CMD_SNOOZE, 32'd710, 1'b1);        // rearm one snooze later
      send_item(CMD_TICK, 32'd771, 1'b1);          // limit fires again
      send_item(CMD_TICK, 32'd780, 1'b0);          // stopped
      send_item(CMD_TICK, 32'd1000, 1'b0);         // limit fires again ahead of the due auto-reset
      send_item(CMD_TICK, 32'd1001, 1'b1);         // started
      send_item(CMD_TICK, 32'd1011, 1'b0);         // stopped
      send_item(CMD_TICK, 32'd1200, 1'b0);         // limit fires again ahead of the due auto-reset
      send_item(CMD_RESET, 32'd1201, 1'b1);
      send_item(CMD_DISABLE, 32'd1202, 1'b0);
      send_item(CMD_TICK, 32'd1203, 1'b1);         // disabled tick
      send_item(CMD_ENABLE, 32'hFFFF_FFF0, 1'b0);
      send_item(CMD_TICK, 32'hFFFF_FFF8, 1'b1);
      send_item(CMD_TICK, 32'h0000_0004, 1'b1);    // time wraps past zero
      send_item(CMD_TICK, 32'h0000_0010, 1'b0);
      send_item(CMD_TICK, 32'h8000_0000, 1'b0);
      settle();

      // Random sessions, each under its own configuration.
      for (int p = 0; p < 10; p++) begin
         limit        = 16'($urandom_range(0, 80));
         limit_en     = ($urandom_range(0, 3) != 0);
         snooze       = 16'($urandom_range(0, 40));
         ar_en        = ($urandom_range(0, 3) != 0);
         ar_span      = 16'($urandom_range(0, 100));
         count_active = 1'($urandom_range(0, 1));
         case (p)
            0: begin
               limit = 16'd30; snooze = 16'd10; ar_span = 16'd40;
               limit_en = 1'b1; ar_en = 1'b1; count_active = 1'b1;
            end
            1: begin
               limit = 16'd0; snooze = 16'd0; ar_span = 16'd0;
               limit_en = 1'b1; ar_en = 1'b1;
            end
            2: begin
               limit = 16'hFFFF; snooze = 16'hFFFF; ar_span = 16'hFFFF;
               limit_en = 1'b1; ar_en = 1'b1; count_active = 1'b0;
            end
            3: begin
               limit_en = 1'b0; ar_en = 1'b0;
            end
            default: ;
         endcase
         load_config(limit, limit_en, snooze, ar_en, ar_span, count_active);
         span = 32'(limit);
         if (32'(ar_span) > span) span = 32'(ar_span);
         if (32'(snooze) > span) span = 32'(snooze);
         span += 10;
         // cross the wrap of the time field, then jump to an arbitrary time
         if (p == 4) wall_s = 32'hFFFF_FE00;
         if (p == 5) wall_s = $urandom();
         // hold the receiver off for a long stretch while items keep coming
         if (p == 3) long_hold = 1'b1;
         // run the final sessions back to back with no idling
         if (p >= 8) idling = 1'b0;
         play_session(145, span);
         settle();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== activity_break_timer.f =====
hdl/abt_pkg.sv
hdl/abt_csr.sv
hdl/abt_core.sv
hdl/activity_break_timer.sv
verif/abt_checker.sv
verif/testbench.sv
